// ----- hdl/mbrx_pkg.sv -----
package mbrx_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FUNC,
        PH_COUNT,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD     = 2'd2,
        ST_ABORTED = 2'd3
    } t_status;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [23:0] TIMEOUT_RST  = 24'd1000000;
    localparam logic [23:0] TICK_MAX     = 24'hFFFFFF;
    localparam logic [8:0]  EXC_LEN      = 9'd5;
    localparam logic [8:0]  HDR_LEN      = 9'd3;
    localparam logic [8:0]  LEN_OVERHEAD = 9'd5;
    localparam int          EXC_BIT      = 7;

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/modbus_rtu_response_receiver.sv -----
// Modbus RTU response receiver: frames bytes, checks CRC-16/MODBUS, aborts on tick timeout.
// The result is registered and valid on the master side in the cycle after the input transfer.
// Throughput: 1 item per cycle when not stalled; byte-wide CRC and framing are combinational.
// A stalled result register still takes a new item in the cycle it is drained.
// Reset (i_rst_n low, synchronous): frame state cleared, CRC to 0xFFFF, timeout to 1000000,
// output empty.
module modbus_rtu_response_receiver #(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,    // timeout_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] mode (1 = tick)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] byte_out, [15:8] byte_position,
                                        // [17:16] frame_status, [18] is_exception,
                                        // [26:19] function_code, [35:27] frame_length,
                                        // [39:36] zero
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] byte_dropped
    output logic        m_axis_tlast    // frame_end
);

    localparam logic [8:0] MAX_CNT = 9'(MAX_FRAME);

    mbrx_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_func, n_func;
    logic [8:0]  r_expected, n_expected;
    logic [8:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_tail, n_tail;
    logic [23:0] r_elapsed, n_elapsed;
    logic [23:0] r_timeout;

    logic        r_o_valid;
    logic [7:0]  r_o_byte, n_o_byte;
    logic [7:0]  r_o_pos, n_o_pos;
    logic        r_o_bvalid, n_o_bvalid;
    logic        r_o_drop, n_o_drop;
    logic        r_o_end, n_o_end;
    mbrx_pkg::t_status r_o_status, n_o_status;
    logic [7:0]  r_o_func, n_o_func;
    logic [8:0]  r_o_len, n_o_len;

    logic        w_accept;
    logic        w_tick;
    logic [7:0]  w_b;
    logic        w_full;
    logic        w_store;
    logic [8:0]  w_cnt_inc;
    logic [23:0] w_elapsed_inc;
    logic        w_abort;
    logic [15:0] w_tail;
    logic [15:0] w_crc;
    logic        w_done;
    logic        w_good;
    logic [7:0]  w_func_now;

    assign s_axis_tready = !r_o_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_tick        = s_axis_tuser[0];
    assign w_b           = s_axis_tdata;
    assign w_full        = r_count >= MAX_CNT;
    assign w_store       = !w_tick && !w_full;
    assign w_cnt_inc     = r_count + 9'd1;
    assign w_elapsed_inc = (r_elapsed == mbrx_pkg::TICK_MAX) ? r_elapsed : r_elapsed + 24'd1;
    assign w_abort       = w_tick && (r_phase != mbrx_pkg::PH_IDLE) &&
                           (w_elapsed_inc > r_timeout);
    assign w_tail        = {r_tail[7:0], w_b};
    // a byte enters the CRC only as it leaves the two-byte tail line
    assign w_crc         = (r_count >= 9'd2) ? mbrx_pkg::crc16_feed(r_crc, r_tail[15:8]) : r_crc;
    assign w_done        = w_store && (r_phase == mbrx_pkg::PH_BODY) && (w_cnt_inc >= r_expected);
    assign w_good        = (w_tail[15:8] == w_crc[7:0]) && (w_tail[7:0] == w_crc[15:8]);

    always_comb begin
        unique case (r_phase)
            mbrx_pkg::PH_IDLE:  w_func_now = 8'h00;
            mbrx_pkg::PH_FUNC:  w_func_now = w_b;
            mbrx_pkg::PH_COUNT: w_func_now = r_func;
            mbrx_pkg::PH_BODY:  w_func_now = r_func;
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_store) begin
            unique case (r_phase)
                mbrx_pkg::PH_IDLE:  n_phase = mbrx_pkg::PH_FUNC;
                mbrx_pkg::PH_FUNC:  n_phase = w_b[mbrx_pkg::EXC_BIT] ? mbrx_pkg::PH_BODY
                                                                     : mbrx_pkg::PH_COUNT;
                mbrx_pkg::PH_COUNT: n_phase = mbrx_pkg::PH_BODY;
                mbrx_pkg::PH_BODY:  n_phase = mbrx_pkg::PH_BODY;
            endcase
        end
        if (w_abort || w_done) begin
            n_phase = mbrx_pkg::PH_IDLE;
        end
    end

    // frame datapath and result
    always_comb begin
        n_func     = r_func;
        n_expected = r_expected;
        n_count    = r_count;
        n_crc      = r_crc;
        n_tail     = r_tail;
        n_elapsed  = r_elapsed;

        n_o_byte   = 8'h00;
        n_o_pos    = 8'h00;
        n_o_bvalid = 1'b0;
        n_o_drop   = 1'b0;
        n_o_end    = 1'b0;
        n_o_status = mbrx_pkg::ST_NONE;
        n_o_func   = 8'h00;
        n_o_len    = 9'd0;

        if (w_tick) begin
            if (r_phase != mbrx_pkg::PH_IDLE) begin
                n_elapsed = w_elapsed_inc;
            end
            if (w_abort) begin
                n_o_end    = 1'b1;
                n_o_status = mbrx_pkg::ST_ABORTED;
                n_o_func   = r_func;
                n_o_len    = r_count;
            end
        end else if (w_full) begin
            n_o_byte = w_b;
            n_o_drop = 1'b1;
            n_o_func = r_func;
        end else begin
            n_crc   = w_crc;
            n_tail  = w_tail;
            n_count = w_cnt_inc;
            unique case (r_phase)
                mbrx_pkg::PH_IDLE: begin
                    n_elapsed = 24'd0;
                    n_func    = 8'h00;
                end
                mbrx_pkg::PH_FUNC: begin
                    n_func     = w_b;
                    n_expected = w_b[mbrx_pkg::EXC_BIT] ? mbrx_pkg::EXC_LEN : mbrx_pkg::HDR_LEN;
                end
                mbrx_pkg::PH_COUNT: begin
                    n_expected = {1'b0, w_b} + mbrx_pkg::LEN_OVERHEAD;
                end
                mbrx_pkg::PH_BODY: begin
                end
            endcase
            n_o_byte   = w_b;
            n_o_pos    = r_count[7:0];
            n_o_bvalid = 1'b1;
            n_o_func   = w_func_now;
            if (w_done) begin
                n_o_end    = 1'b1;
                n_o_status = w_good ? mbrx_pkg::ST_GOOD : mbrx_pkg::ST_BAD;
                n_o_len    = w_cnt_inc;
            end
        end

        if (w_abort || w_done) begin
            n_func     = 8'h00;
            n_expected = 9'd0;
            n_count    = 9'd0;
            n_crc      = mbrx_pkg::CRC_INIT;
            n_tail     = 16'h0000;
            n_elapsed  = 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mbrx_pkg::PH_IDLE;
            r_func     <= 8'h00;
            r_expected <= 9'd0;
            r_count    <= 9'd0;
            r_crc      <= mbrx_pkg::CRC_INIT;
            r_tail     <= 16'h0000;
            r_elapsed  <= 24'd0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_func     <= n_func;
            r_expected <= n_expected;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_tail     <= n_tail;
            r_elapsed  <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= mbrx_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_accept) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o_byte   <= n_o_byte;
            r_o_pos    <= n_o_pos;
            r_o_bvalid <= n_o_bvalid;
            r_o_drop   <= n_o_drop;
            r_o_end    <= n_o_end;
            r_o_status <= n_o_status;
            r_o_func   <= n_o_func;
            r_o_len    <= n_o_len;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_o_end;
    assign m_axis_tuser  = {r_o_drop, r_o_bvalid};
    assign m_axis_tdata  = {4'h0, r_o_len, r_o_func, r_o_func[mbrx_pkg::EXC_BIT],
                            r_o_status, r_o_pos, r_o_byte};

    // frame end always reports a status; none otherwise
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_o_status != mbrx_pkg::ST_NONE)))
        else $error("frame_end and frame_status disagree");

    a_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_o_bvalid && r_o_drop))
        else $error("byte both stored and dropped");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_abort || w_done)) |=>
            (r_phase == mbrx_pkg::PH_IDLE) && (r_count == 9'd0) &&
            (r_crc == mbrx_pkg::CRC_INIT))
        else $error("frame state not cleared after frame end");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("byte count past frame limit");

endmodule
